@@ hw/rtl/tea_pkg.sv @@
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and round functions of the TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

	localparam int TEA_WORD_W   = 32;
	localparam int TEA_ROUNDS   = 32;
	localparam int TEA_STAGES   = 2 * TEA_ROUNDS;
	localparam int TEA_SHL      = 4;
	localparam int TEA_SHR      = 5;
	localparam int TEA_CFG_IDX_W = 8;

	localparam logic [TEA_WORD_W-1:0] TEA_DELTA   = 32'h9E37_79B9;
	localparam logic [TEA_WORD_W-1:0] TEA_DEC_SUM = 32'hC6EF_3720;

	// configuration register indexes
	localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY0 = 8'd0;
	localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY1 = 8'd1;
	localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY2 = 8'd2;
	localparam logic [TEA_CFG_IDX_W-1:0] REG_KEY3 = 8'd3;

	typedef logic [TEA_WORD_W-1:0] tea_word_t;

	typedef struct packed {
		tea_word_t k0;
		tea_word_t k1;
		tea_word_t k2;
		tea_word_t k3;
	} tea_key_t;

	typedef struct packed {
		logic      dec;
		tea_word_t a;
		tea_word_t b;
	} tea_blk_t;

	function automatic tea_word_t tea_mix(input tea_word_t h, input tea_word_t sum,
		input tea_word_t ka, input tea_word_t kb);
		return ((h << TEA_SHL) + ka) ^ (h + sum) ^ ((h >> TEA_SHR) + kb);
	endfunction

	// running sum used by encryption round r
	function automatic tea_word_t tea_enc_sum(input int r);
		return TEA_WORD_W'(64'(TEA_DELTA) * 64'(r + 1));
	endfunction

	// running sum used by decryption round r
	function automatic tea_word_t tea_dec_sum(input int r);
		return TEA_DEC_SUM - TEA_WORD_W'(64'(TEA_DELTA) * 64'(r));
	endfunction

endpackage

@@ hw/rtl/tea_req_if.sv @@
// ----------------------------------------------------------------------------
// tea_req_if
// Request channel: operation select and one 64-bit block as two words.
// ----------------------------------------------------------------------------
interface tea_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] text_first;
	logic [31:0] text_second;

	modport source (output valid, output req_type, output text_first,
		output text_second, input ready);
	modport sink (input valid, input req_type, input text_first,
		input text_second, output ready);
endinterface

@@ hw/rtl/tea_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tea_rsp_if
// Response channel: one transformed 64-bit block as two words.
// ----------------------------------------------------------------------------
interface tea_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_first;
	logic [31:0] result_second;

	modport source (output valid, output result_first, output result_second,
		input ready);
	modport sink (input valid, input result_first, input result_second,
		output ready);
endinterface

@@ hw/rtl/tea_stage.sv @@
// ----------------------------------------------------------------------------
// tea_stage
// One half-round pipeline stage: updates one word of the block from the other.
// ----------------------------------------------------------------------------
module tea_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              odd,
	input  tea_pkg::tea_word_t enc_sum,
	input  tea_pkg::tea_word_t dec_sum,
	input  tea_pkg::tea_key_t key,
	input  logic              in_vld,
	input  tea_pkg::tea_blk_t in_blk,
	output logic              out_vld,
	output tea_pkg::tea_blk_t out_blk
);
	import tea_pkg::*;

	logic      upd_a;
	tea_word_t src;
	tea_word_t dst;
	tea_word_t ka;
	tea_word_t kb;
	tea_word_t sum;
	tea_word_t mix;
	tea_word_t res;
	tea_blk_t  nxt;
	logic      vld_s1;
	tea_blk_t  blk_s1;

	// encryption: even stage updates a, odd stage updates b; decryption the reverse
	always_comb begin
		upd_a = ~(odd ^ in_blk.dec);
		src   = upd_a ? in_blk.b : in_blk.a;
		dst   = upd_a ? in_blk.a : in_blk.b;
		ka    = upd_a ? key.k0 : key.k2;
		kb    = upd_a ? key.k1 : key.k3;
		sum   = in_blk.dec ? dec_sum : enc_sum;
		mix   = tea_mix(src, sum, ka, kb);
		res   = in_blk.dec ? (dst - mix) : (dst + mix);
		nxt   = in_blk;
		if (upd_a) begin
			nxt.a = res;
		end else begin
			nxt.b = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_blk = blk_s1;

endmodule

@@ hw/rtl/tea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// tea_block_cipher
// 32-round TEA encrypt/decrypt of 64-bit blocks under a 128-bit key.
//
//   channel   dir   payload                                 handshake
//   req       in    req_type, text_first, text_second       valid/ready
//   rsp       out   result_first, result_second             valid/ready
//   cfg       in    cfg_idx, cfg_wdata (key words 0..3)     cfg_we
//
// one half-round per stage, 64 stages; one block per cycle while rsp is not stalled
// reset clears the stage valid bits and the key words
// a stalled response freezes the whole pipeline; bubbles still move while the
// output stage is empty, so req.ready = rsp.ready | ~rsp.valid
// ----------------------------------------------------------------------------
module tea_block_cipher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tea_pkg::TEA_CFG_IDX_W-1:0]   cfg_idx,
	input  tea_pkg::tea_word_t                  cfg_wdata,
	tea_req_if.sink                             req,
	tea_rsp_if.source                           rsp
);
	import tea_pkg::*;

	tea_key_t key_q;
	logic     en;
	logic     stage_vld [TEA_STAGES+1];
	tea_blk_t stage_blk [TEA_STAGES+1];

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_KEY0: key_q.k0 <= cfg_wdata;
				REG_KEY1: key_q.k1 <= cfg_wdata;
				REG_KEY2: key_q.k2 <= cfg_wdata;
				REG_KEY3: key_q.k3 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en        = rsp.ready | ~rsp.valid;
	assign req.ready = en;

	assign stage_vld[0]     = req.valid;
	assign stage_blk[0].dec = req.req_type;
	assign stage_blk[0].a   = req.text_first;
	assign stage_blk[0].b   = req.text_second;

	for (genvar i = 0; i < TEA_STAGES; i++) begin : g_stage
		localparam tea_word_t ENC_SUM = tea_enc_sum(i / 2);
		localparam tea_word_t DEC_SUM = tea_dec_sum(i / 2);

		tea_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.odd     (1'(i % 2)),
			.enc_sum (ENC_SUM),
			.dec_sum (DEC_SUM),
			.key     (key_q),
			.in_vld  (stage_vld[i]),
			.in_blk  (stage_blk[i]),
			.out_vld (stage_vld[i+1]),
			.out_blk (stage_blk[i+1])
		);
	end

	assign rsp.valid         = stage_vld[TEA_STAGES];
	assign rsp.result_first  = stage_blk[TEA_STAGES].a;
	assign rsp.result_second = stage_blk[TEA_STAGES].b;

`ifndef SYNTHESIS
	a_key_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(key_q))
		else $error("key changed without a config write");

	a_first_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> stage_vld[1])
		else $error("accepted transaction missing from first stage");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(stage_vld[1]) && $stable(stage_vld[TEA_STAGES/2])))
		else $error("pipeline moved during stall");
`endif

endmodule
